// ===== rtl/core/gqtl_pkg.sv =====
// ============================================================================
// gqtl_pkg
// Types and constants shared by the glyph quad text layout modules.
// ============================================================================
`default_nettype none
package gqtl_pkg;

  localparam int GLYPH_SLOTS = 256;
  localparam int SLOT_BITS   = $clog2(GLYPH_SLOTS);
  localparam int POS_BITS    = 24;
  localparam int OUT_POS_BITS = 24;
  localparam int TEX_BITS    = 17;
  localparam int DIV_STEPS   = TEX_BITS;
  localparam logic [TEX_BITS-1:0] TEX_MAX = '1;
  localparam logic [15:0] PEN_Y_RESET = 16'd480;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CHAR  = 2'd2;

  localparam logic [1:0] REG_ATLAS_W  = 2'd0;
  localparam logic [1:0] REG_ATLAS_H  = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd3;

  typedef struct packed {
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [15:0]        w;
    logic [15:0]        h;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] adv;
  } glyph_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/glyph_quad_text_layout.sv =====
// ============================================================================
// glyph_quad_text_layout
// Glyph table and text-to-quad layout engine.
//
// Input channel (in_valid/in_stall) carries load, start and character beats.
// A load writes one glyph record; a start puts the pen at the origin and
// clears the glyph count; a character whose glyph is present yields four
// vertex beats on the output channel (out_valid/out_stall), corner 0..3,
// with last on corner 3. Codes at or above the table size are dropped.
// A character passes through the table read, the four parallel bit-serial
// texture dividers (17 quotient bits each) and the output of its four
// vertices. A missing glyph returns to idle from the table read state.
// in_stall stays high until the quad is fully delivered; an output stall
// holds the current vertex. Reset clears the present bits at once, sets
// atlas size 256x256, origin (0, 480), pen at origin and count zero.
// Configuration writes take effect at the clock edge of the write.
// ============================================================================
`default_nettype none
module glyph_quad_text_layout
  import gqtl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [15:0]              cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               func,
  input  wire logic [15:0]              char_code,
  input  wire logic [15:0]              atlas_x,
  input  wire logic [15:0]              atlas_y,
  input  wire logic [15:0]              glyph_width,
  input  wire logic [15:0]              glyph_height,
  input  wire logic signed [15:0]       offset_x,
  input  wire logic signed [15:0]       offset_y,
  input  wire logic signed [15:0]       advance_x,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [OUT_POS_BITS-1:0] pos_x,
  output logic signed [OUT_POS_BITS-1:0] pos_y,
  output logic [TEX_BITS-1:0]           tex_u,
  output logic [TEX_BITS-1:0]           tex_v,
  output logic [17:0]                   vertex_index,
  output logic [1:0]                    corner,
  output logic                          last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] atlas_w, atlas_h;
  logic [15:0] origin_x, origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w  <= 16'd256;
      atlas_h  <= 16'd256;
      origin_x <= '0;
      origin_y <= PEN_Y_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ATLAS_W:  atlas_w  <= cfg_data;
        REG_ATLAS_H:  atlas_h  <= cfg_data;
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic in_take;
  logic code_ok;
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign code_ok  = (char_code < 16'(GLYPH_SLOTS));

  // glyph table
  glyph_rec_t wrec, rrec;
  logic       rpresent;
  assign wrec = '{ax: atlas_x, ay: atlas_y, w: glyph_width, h: glyph_height,
                  ox: offset_x, oy: offset_y, adv: advance_x};

  gqtl_glyph_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .we       (in_take && func == FUNC_LOAD && code_ok),
    .waddr    (char_code[SLOT_BITS-1:0]),
    .wdata    (wrec),
    .raddr    (char_code[SLOT_BITS-1:0]),
    .rdata    (rrec),
    .rpresent (rpresent)
  );

  // texture dividers: u0, u1, v0, v1
  logic                div_start;
  logic [3:0]          div_done;
  logic [TEX_BITS-1:0] div_texel [4];
  logic [TEX_BITS-1:0] div_q [4];
  logic [15:0]         div_size [4];

  assign div_start    = (state == S_READ) && rpresent;
  assign div_texel[0] = {1'b0, rrec.ax};
  assign div_texel[1] = {1'b0, rrec.ax} + {1'b0, rrec.w};
  assign div_texel[2] = {1'b0, rrec.ay};
  assign div_texel[3] = {1'b0, rrec.ay} + {1'b0, rrec.h};
  assign div_size[0]  = atlas_w;
  assign div_size[1]  = atlas_w;
  assign div_size[2]  = atlas_h;
  assign div_size[3]  = atlas_h;

  for (genvar i = 0; i < 4; i++) begin : g_div
    gqtl_tex_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .texel (div_texel[i]),
      .size  (div_size[i]),
      .done  (div_done[i]),
      .quot  (div_q[i])
    );
  end

  // pen, count and quad geometry
  logic [POS_BITS-1:0] pen_x, pen_y;
  logic [15:0]         quad_count;
  logic [POS_BITS-1:0] x0, x1, y0, y1;
  logic [POS_BITS-1:0] x0_next, y0_next;
  logic [POS_BITS-1:0] adv;
  logic [1:0]          corner_cnt;
  logic                out_take;

  assign x0_next  = pen_x + POS_BITS'(rrec.ox);
  assign y0_next  = pen_y - POS_BITS'(rrec.oy);
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      x0  <= x0_next;
      y0  <= y0_next;
      x1  <= x0_next + POS_BITS'(rrec.w);
      y1  <= y0_next - POS_BITS'(rrec.h);
      adv <= POS_BITS'(rrec.adv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pen_x      <= '0;
      pen_y      <= POS_BITS'(PEN_Y_RESET);
      quad_count <= '0;
      corner_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (func == FUNC_START) begin
              pen_x      <= POS_BITS'(signed'(origin_x));
              pen_y      <= POS_BITS'(signed'(origin_y));
              quad_count <= '0;
            end else if (func == FUNC_CHAR && code_ok) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // drop characters whose glyph was never loaded
          state <= rpresent ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (&div_done) begin
            state      <= S_EMIT;
            corner_cnt <= '0;
          end
        end
        S_EMIT: begin
          if (out_take) begin
            corner_cnt <= corner_cnt + 1'b1;
            if (corner_cnt == 2'd3) begin
              pen_x      <= pen_x + adv;
              quad_count <= quad_count + 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // vertex select: corner 0 BL, 1 TL, 2 TR, 3 BR
  logic left, top;
  assign left = (corner_cnt == 2'd0) || (corner_cnt == 2'd1);
  assign top  = (corner_cnt == 2'd1) || (corner_cnt == 2'd2);

  assign out_valid    = (state == S_EMIT);
  assign pos_x        = OUT_POS_BITS'(left ? x0 : x1);
  assign pos_y        = OUT_POS_BITS'(top ? y0 : y1);
  assign tex_u        = left ? div_q[0] : div_q[1];
  assign tex_v        = top ? div_q[2] : div_q[3];
  assign vertex_index = {quad_count, corner_cnt};
  assign corner       = corner_cnt;
  assign last         = (corner_cnt == 2'd3);

`ifndef SYNTHESIS
  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> corner == 2'd0)
    else $error("quad does not start at corner 0");

  a_quad_ends: assert property (@(posedge clk) disable iff (rst)
    (out_take && last) |=> !out_valid && !in_stall)
    else $error("output continues after last vertex");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> (&div_done))
    else $error("texture dividers out of step");

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> state == S_DIV)
    else $error("divider finished outside the wait state");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/gqtl_glyph_ram.sv =====
// ============================================================================
// gqtl_glyph_ram
// Glyph record memory with one registered read port and per-slot present bits.
// ============================================================================
`default_nettype none
module gqtl_glyph_ram
  import gqtl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 we,
  input  wire logic [SLOT_BITS-1:0] waddr,
  input  wire glyph_rec_t           wdata,
  input  wire logic [SLOT_BITS-1:0] raddr,
  output glyph_rec_t                rdata,
  output logic                      rpresent
);

  glyph_rec_t mem [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0] present;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      rpresent <= 1'b0;
    end else begin
      if (we) begin
        present[waddr] <= 1'b1;
      end
      rpresent <= present[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gqtl_tex_div.sv =====
// ============================================================================
// gqtl_tex_div
// Restoring divider: texel * 65536 / size, one quotient bit per cycle,
// saturated to the 1.16 range.
// ============================================================================
`default_nettype none
module gqtl_tex_div
  import gqtl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [TEX_BITS-1:0] texel,
  input  wire logic [15:0]         size,
  output logic                     done,
  output logic [TEX_BITS-1:0]      quot
);

  localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

  logic                active;
  logic [CNT_BITS-1:0] cnt;
  logic                sat;
  logic [15:0]         divisor;
  logic [15:0]         rem;
  logic [TEX_BITS-1:0] bits;
  logic [TEX_BITS-1:0] q;
  logic [16:0]         trial;
  logic                fits;

  assign trial = {rem, bits[TEX_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign quot  = sat ? TEX_MAX : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_BITS'(DIV_STEPS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // quotient overflows 17 bits exactly when texel >= 2 * size (also size zero)
  always_ff @(posedge clk) begin
    if (start) begin
      sat     <= {1'b0, texel} >= {1'b0, size, 1'b0};
      divisor <= size;
      rem     <= texel[TEX_BITS-1:1];
      bits    <= {texel[0], {(TEX_BITS-1){1'b0}}};
      q       <= '0;
    end else if (active) begin
      rem  <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      bits <= {bits[TEX_BITS-2:0], 1'b0};
      q    <= {q[TEX_BITS-2:0], fits};
    end
  end

endmodule
`default_nettype wire
